FILE: rtl/crx_pkg.sv
`default_nettype none
package crx_pkg;

  typedef enum logic [2:0] {
    VERDICT_OK         = 3'd0,
    VERDICT_SHORT      = 3'd1,
    VERDICT_LEN_MISMATCH = 3'd2,
    VERDICT_BAD_CSUM   = 3'd3,
    VERDICT_WRONG_TYPE = 3'd4
  } verdict_t;

  // Light commands carried in the first payload byte
  localparam logic [7:0] CMD_FRONT_ON  = 8'h01;
  localparam logic [7:0] CMD_FRONT_OFF = 8'h02;
  localparam logic [7:0] CMD_REAR_ON   = 8'h03;
  localparam logic [7:0] CMD_REAR_OFF  = 8'h04;
  localparam logic [7:0] CMD_BODY_ON   = 8'h05;
  localparam logic [7:0] CMD_BODY_OFF  = 8'h06;

  localparam int unsigned COUNT_W = 9;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;
  localparam logic [COUNT_W-1:0] MIN_FRAME = 9'd7;
  // Byte positions of the captured header fields
  localparam logic [COUNT_W-1:0] POS_TYPE    = 9'd0;
  localparam logic [COUNT_W-1:0] POS_LENGTH  = 9'd5;
  localparam logic [COUNT_W-1:0] POS_PAYLOAD = 9'd6;
  // Header bytes plus checksum byte around the payload
  localparam logic [COUNT_W:0]   FRAME_OVERHEAD = 10'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_write;
  } byte_beat_t;

  typedef struct packed {
    verdict_t   verdict;
    logic [7:0] command_code;
    logic       front_lamp;
    logic       rear_lamp;
    logic       body_lamp;
  } frame_result_t;

endpackage
`default_nettype wire

FILE: rtl/crx_in_reg.sv
`default_nettype none
module crx_in_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire logic              valid_in,
  input  wire crx_pkg::byte_beat_t beat_in,
  output crx_pkg::byte_beat_t    beat_r,
  output logic                   valid_r
);

  logic valid_nxt;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload holds unless a new beat loads
  always_ff @(posedge clk) begin
    if (load && valid_in) begin
      beat_r <= beat_in;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/crx_frame_core.sv
`default_nettype none
module crx_frame_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                beat_go,
  input  wire crx_pkg::byte_beat_t beat,
  input  wire logic [7:0]          ctrl_type,
  output crx_pkg::frame_result_t   result,
  output logic                     result_go
);

  logic [crx_pkg::COUNT_W-1:0] byte_count_r, byte_count_nxt, count_inc;
  logic [7:0] running_xor_r, running_xor_nxt, xor_inc;
  logic [7:0] frame_type_r, frame_type_nxt;
  logic [7:0] declared_length_r, declared_length_nxt;
  logic [7:0] first_payload_r, first_payload_nxt;
  logic       front_r, front_nxt;
  logic       rear_r, rear_nxt;
  logic       body_r, body_nxt;
  logic [crx_pkg::COUNT_W:0] expected_total;
  crx_pkg::verdict_t verdict;

  always_comb begin
    frame_type_nxt      = frame_type_r;
    declared_length_nxt = declared_length_r;
    first_payload_nxt   = first_payload_r;
    if (beat_go) begin
      if (byte_count_r == crx_pkg::POS_TYPE) begin
        frame_type_nxt = beat.data_byte;
      end else if (byte_count_r == crx_pkg::POS_LENGTH) begin
        declared_length_nxt = beat.data_byte;
      end else if (byte_count_r == crx_pkg::POS_PAYLOAD) begin
        first_payload_nxt = beat.data_byte;
      end
    end

    xor_inc   = running_xor_r ^ beat.data_byte;
    // Saturate the count on overlong writes
    count_inc = (byte_count_r == crx_pkg::COUNT_MAX) ? byte_count_r
              : byte_count_r + {{(crx_pkg::COUNT_W-1){1'b0}}, 1'b1};
    expected_total = {2'b00, declared_length_nxt} + crx_pkg::FRAME_OVERHEAD;

    if (count_inc < crx_pkg::MIN_FRAME) begin
      verdict = crx_pkg::VERDICT_SHORT;
    end else if ({1'b0, count_inc} != expected_total) begin
      verdict = crx_pkg::VERDICT_LEN_MISMATCH;
    end else if (xor_inc != 8'h00) begin
      verdict = crx_pkg::VERDICT_BAD_CSUM;
    end else if (frame_type_nxt != ctrl_type) begin
      verdict = crx_pkg::VERDICT_WRONG_TYPE;
    end else begin
      verdict = crx_pkg::VERDICT_OK;
    end

    result_go = beat_go && beat.end_of_write;

    front_nxt = front_r;
    rear_nxt  = rear_r;
    body_nxt  = body_r;
    if (result_go && verdict == crx_pkg::VERDICT_OK) begin
      case (first_payload_nxt)
        crx_pkg::CMD_FRONT_ON:  front_nxt = 1'b1;
        crx_pkg::CMD_FRONT_OFF: front_nxt = 1'b0;
        crx_pkg::CMD_REAR_ON:   rear_nxt  = 1'b1;
        crx_pkg::CMD_REAR_OFF:  rear_nxt  = 1'b0;
        crx_pkg::CMD_BODY_ON:   body_nxt  = 1'b1;
        crx_pkg::CMD_BODY_OFF:  body_nxt  = 1'b0;
        default: ;
      endcase
    end

    byte_count_nxt  = byte_count_r;
    running_xor_nxt = running_xor_r;
    if (beat_go) begin
      // Clear the frame accumulators after the last beat of a write
      byte_count_nxt  = beat.end_of_write ? '0 : count_inc;
      running_xor_nxt = beat.end_of_write ? 8'h00 : xor_inc;
    end

    result.verdict      = verdict;
    result.command_code = (verdict == crx_pkg::VERDICT_OK) ? first_payload_nxt : 8'h00;
    result.front_lamp   = front_nxt;
    result.rear_lamp    = rear_nxt;
    result.body_lamp    = body_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r      <= '0;
      running_xor_r     <= 8'h00;
      frame_type_r      <= 8'h00;
      declared_length_r <= 8'h00;
      first_payload_r   <= 8'h00;
      front_r           <= 1'b0;
      rear_r            <= 1'b0;
      body_r            <= 1'b0;
    end else begin
      byte_count_r      <= byte_count_nxt;
      running_xor_r     <= running_xor_nxt;
      frame_type_r      <= frame_type_nxt;
      declared_length_r <= declared_length_nxt;
      first_payload_r   <= first_payload_nxt;
      front_r           <= front_nxt;
      rear_r            <= rear_nxt;
      body_r            <= body_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/crx_out_reg.sv
`default_nettype none
module crx_out_reg (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  load,
  input  wire crx_pkg::frame_result_t result_in,
  input  wire logic                  stall,
  output crx_pkg::frame_result_t     result_r,
  output logic                       valid_r
);

  logic valid_nxt;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result_in;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/control_frame_receiver.sv
`default_nettype none
// Control frame receiver: per-byte XOR checksum deframer with light control.
// A write's last byte passes the input register, its result the result register.
// Throughput: one byte beat per cycle; the input register and the result
//   register decouple the two sides, so only a held result blocks a last byte.
// Reset: synchronous, active low; clears counters, captures, lights and the
//   control type register; no clearing pass, ready in the first cycle after.
module control_frame_receiver (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // byte input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_end_of_write,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_verdict,
  output logic [7:0]      out_command_code,
  output logic            out_front_lamp,
  output logic            out_rear_lamp,
  output logic            out_body_lamp,
  // control type register write port
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_control_type_code
);

  crx_pkg::byte_beat_t    in_beat, s1_beat;
  crx_pkg::frame_result_t core_result, out_result;
  logic s1_valid;
  logic s1_adv;
  logic result_go;
  logic out_valid_int;
  logic [7:0] ctrl_type_r, ctrl_type_nxt;

  assign in_beat.data_byte    = in_data_byte;
  assign in_beat.end_of_write = in_end_of_write;

  // Advance the held beat unless it would produce a result and the result
  // register is still waiting on the consumer. Non-last bytes always advance.
  assign s1_adv   = s1_valid && (!s1_beat.end_of_write || !out_valid_int || !out_stall);
  assign in_stall = s1_valid && !s1_adv;

  crx_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (!in_stall),
    .valid_in (in_valid),
    .beat_in  (in_beat),
    .beat_r   (s1_beat),
    .valid_r  (s1_valid)
  );

  crx_frame_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_go   (s1_adv),
    .beat      (s1_beat),
    .ctrl_type (ctrl_type_r),
    .result    (core_result),
    .result_go (result_go)
  );

  crx_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (result_go),
    .result_in (core_result),
    .stall     (out_stall),
    .result_r  (out_result),
    .valid_r   (out_valid_int)
  );

  // Config writes land any cycle; the port is always ready.
  assign cfg_ready = 1'b1;

  always_comb begin
    ctrl_type_nxt = ctrl_type_r;
    if (cfg_valid && cfg_ready) begin
      ctrl_type_nxt = cfg_control_type_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_type_r <= 8'h00;
    end else begin
      ctrl_type_r <= ctrl_type_nxt;
    end
  end

  assign out_valid        = out_valid_int;
  assign out_verdict      = out_result.verdict;
  assign out_command_code = out_result.command_code;
  assign out_front_lamp   = out_result.front_lamp;
  assign out_rear_lamp    = out_result.rear_lamp;
  assign out_body_lamp    = out_result.body_lamp;

endmodule
`default_nettype wire

FILE: rtl/crx_checker.sv
`default_nettype none
module crx_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [2:0] out_verdict,
  input wire logic [7:0] out_command_code,
  input wire logic       out_front_lamp,
  input wire logic       out_rear_lamp,
  input wire logic       out_body_lamp
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_verdict)
      && $stable(out_command_code))
    else $error("stalled result beat changed");

  // Drop the result after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A rejected frame carries no command
  a_reject_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict != crx_pkg::VERDICT_OK |-> out_command_code == 8'h00)
    else $error("rejected frame reports a command");

  // An accepted light command shows in the reported light state
  a_cmd_applied: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict == crx_pkg::VERDICT_OK |->
      (out_command_code != crx_pkg::CMD_FRONT_ON  || out_front_lamp) &&
      (out_command_code != crx_pkg::CMD_FRONT_OFF || !out_front_lamp) &&
      (out_command_code != crx_pkg::CMD_REAR_ON   || out_rear_lamp) &&
      (out_command_code != crx_pkg::CMD_REAR_OFF  || !out_rear_lamp) &&
      (out_command_code != crx_pkg::CMD_BODY_ON   || out_body_lamp) &&
      (out_command_code != crx_pkg::CMD_BODY_OFF  || !out_body_lamp))
    else $error("accepted command not reflected in light state");

endmodule

bind control_frame_receiver crx_checker u_crx_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_verdict      (out_verdict),
  .out_command_code (out_command_code),
  .out_front_lamp   (out_front_lamp),
  .out_rear_lamp    (out_rear_lamp),
  .out_body_lamp    (out_body_lamp)
);
`default_nettype wire

FILE: test/tb_top.sv
module tb_top;

  // One directed frame: how to build it and, where it is obvious, what must come back
  typedef struct packed {
    logic       set_cfg;      // write the control type before this frame
    logic [7:0] cfg_code;
    logic [7:0] ftype;
    logic [7:0] plen;
    logic [7:0] cmd;
    logic [9:0] n_bytes;      // zero keeps the built length, else cut or pad to it
    logic       bad_sum;
    logic       typed;        // expectation written out below instead of predicted
    crx_pkg::verdict_t want_verdict;
    logic [7:0] want_cmd;
    logic [2:0] want_lights;  // front, rear, body
  } frame_row_t;

  localparam int N_ROWS = 23;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_end_of_write = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_verdict;
  logic [7:0] out_command_code;
  logic       out_front_lamp;
  logic       out_rear_lamp;
  logic       out_body_lamp;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_control_type_code = 8'h00;

  // Shadow of the receiver: byte counter, running XOR, header captures, lights
  logic [8:0] rx_count = '0;
  logic [7:0] rx_xor = '0;
  logic [7:0] rx_type = '0;
  logic [7:0] rx_len = '0;
  logic [7:0] rx_first = '0;
  logic       lamp_front = 1'b0;
  logic       lamp_rear = 1'b0;
  logic       lamp_body = 1'b0;
  logic [7:0] ctrl_type_q = '0;

  crx_pkg::frame_result_t pending_results[$];
  logic [7:0]             frame_bytes[$];

  int mismatches = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int verdict_seen [0:7];
  int in_calm = 0;
  int out_calm = 0;
  int out_hold = 0;

  frame_row_t directed_rows [N_ROWS] = '{
    // right after reset the control type is zero: accept and switch front on
    '{1'b0, 8'h00, 8'h00, 8'd1, crx_pkg::CMD_FRONT_ON, 10'd0, 1'b0,
      1'b1, crx_pkg::VERDICT_OK, crx_pkg::CMD_FRONT_ON, 3'b100},
    // a lone last byte, then a write one byte under the minimum
    '{1'b0, 8'h00, 8'h00, 8'd1, 8'h00, 10'd1, 1'b0,
      1'b1, crx_pkg::VERDICT_SHORT, 8'h00, 3'b100},
    '{1'b0, 8'h00, 8'h00, 8'd1, 8'h00, 10'd6, 1'b0,
      1'b1, crx_pkg::VERDICT_SHORT, 8'h00, 3'b100},
    // top control type
    '{1'b1, 8'hFF, 8'hFF, 8'd1, crx_pkg::CMD_REAR_ON, 10'd0, 1'b0,
      1'b1, crx_pkg::VERDICT_OK, crx_pkg::CMD_REAR_ON, 3'b110},
    // clean frame of the wrong type
    '{1'b0, 8'h00, 8'h00, 8'd1, crx_pkg::CMD_BODY_ON, 10'd0, 1'b0,
      1'b1, crx_pkg::VERDICT_WRONG_TYPE, 8'h00, 3'b110},
    '{1'b0, 8'h00, 8'hFF, 8'd1, crx_pkg::CMD_BODY_ON, 10'd0, 1'b1,
      1'b1, crx_pkg::VERDICT_BAD_CSUM, 8'h00, 3'b110},
    // cut short, declared length at its top, padded past the declared length
    '{1'b0, 8'h00, 8'hFF, 8'd3, crx_pkg::CMD_BODY_ON, 10'd9, 1'b0,
      1'b1, crx_pkg::VERDICT_LEN_MISMATCH, 8'h00, 3'b110},
    '{1'b0, 8'h00, 8'hFF, 8'hFF, crx_pkg::CMD_BODY_ON, 10'd9, 1'b0,
      1'b1, crx_pkg::VERDICT_LEN_MISMATCH, 8'h00, 3'b110},
    '{1'b0, 8'h00, 8'hFF, 8'd2, crx_pkg::CMD_BODY_ON, 10'd12, 1'b0,
      1'b1, crx_pkg::VERDICT_LEN_MISMATCH, 8'h00, 3'b110},
    // walk the remaining light commands
    '{1'b0, 8'h00, 8'hFF, 8'd1, crx_pkg::CMD_BODY_ON, 10'd0, 1'b0,
      1'b1, crx_pkg::VERDICT_OK, crx_pkg::CMD_BODY_ON, 3'b111},
    '{1'b0, 8'h00, 8'hFF, 8'd1, crx_pkg::CMD_FRONT_OFF, 10'd0, 1'b0,
      1'b1, crx_pkg::VERDICT_OK, crx_pkg::CMD_FRONT_OFF, 3'b011},
    '{1'b0, 8'h00, 8'hFF, 8'd1, crx_pkg::CMD_REAR_OFF, 10'd0, 1'b0,
      1'b1, crx_pkg::VERDICT_OK, crx_pkg::CMD_REAR_OFF, 3'b001},
    '{1'b0, 8'h00, 8'hFF, 8'd1, crx_pkg::CMD_BODY_OFF, 10'd0, 1'b0,
      1'b1, crx_pkg::VERDICT_OK, crx_pkg::CMD_BODY_OFF, 3'b000},
    // accepted commands outside the light set leave the lights alone
    '{1'b0, 8'h00, 8'hFF, 8'd1, 8'h00, 10'd0, 1'b0,
      1'b1, crx_pkg::VERDICT_OK, 8'h00, 3'b000},
    '{1'b0, 8'h00, 8'hFF, 8'd3, 8'hFF, 10'd0, 1'b0,
      1'b1, crx_pkg::VERDICT_OK, 8'hFF, 3'b000},
    '{1'b0, 8'h00, 8'hFF, 8'd2, 8'h07, 10'd0, 1'b0,
      1'b1, crx_pkg::VERDICT_OK, 8'h07, 3'b000},
    // back to the bottom control type
    '{1'b1, 8'h00, 8'h00, 8'd1, crx_pkg::CMD_FRONT_ON, 10'd0, 1'b0,
      1'b1, crx_pkg::VERDICT_OK, crx_pkg::CMD_FRONT_ON, 3'b100},
    // bad checksum wins over wrong type, length over checksum
    '{1'b0, 8'h00, 8'h80, 8'd1, crx_pkg::CMD_BODY_ON, 10'd0, 1'b1,
      1'b1, crx_pkg::VERDICT_BAD_CSUM, 8'h00, 3'b100},
    '{1'b0, 8'h00, 8'h00, 8'd5, crx_pkg::CMD_BODY_ON, 10'd8, 1'b0,
      1'b1, crx_pkg::VERDICT_LEN_MISMATCH, 8'h00, 3'b100},
    // short write after a full one: stale captures must not matter
    '{1'b0, 8'h00, 8'h00, 8'd1, crx_pkg::CMD_BODY_ON, 10'd3, 1'b0,
      1'b1, crx_pkg::VERDICT_SHORT, 8'h00, 3'b100},
    // empty payload: the checksum byte lands in the command slot
    '{1'b0, 8'h00, 8'h00, 8'd0, 8'h00, 10'd0, 1'b0,
      1'b0, crx_pkg::VERDICT_OK, 8'h00, 3'b000},
    '{1'b1, 8'h5A, 8'h5A, 8'd4, 8'hA3, 10'd0, 1'b0,
      1'b0, crx_pkg::VERDICT_OK, 8'h00, 3'b000},
    '{1'b0, 8'h00, 8'h5A, 8'd2, crx_pkg::CMD_REAR_ON, 10'd0, 1'b0,
      1'b0, crx_pkg::VERDICT_OK, 8'h00, 3'b000}
  };

  control_frame_receiver u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_data_byte          (in_data_byte),
    .in_end_of_write       (in_end_of_write),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_verdict           (out_verdict),
    .out_command_code      (out_command_code),
    .out_front_lamp        (out_front_lamp),
    .out_rear_lamp         (out_rear_lamp),
    .out_body_lamp         (out_body_lamp),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_control_type_code (cfg_control_type_code)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop in case a handshake hangs
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advance the shadow receiver by one byte; return 1 with the result on a last byte
  function automatic logic deframe_byte(input logic [7:0] data, input logic last,
                                        output crx_pkg::frame_result_t res);
    crx_pkg::verdict_t v;
    logic [7:0]        cmd;
    res = '0;
    // capture header fields by position
    if (rx_count == crx_pkg::POS_TYPE) rx_type = data;
    else if (rx_count == crx_pkg::POS_LENGTH) rx_len = data;
    else if (rx_count == crx_pkg::POS_PAYLOAD) rx_first = data;
    rx_xor ^= data;
    // hold the count once it saturates
    if (rx_count < crx_pkg::COUNT_MAX) rx_count++;
    if (!last) return 1'b0;

    cmd = 8'h00;
    // first failing check wins: size, length, checksum, type
    if (rx_count < crx_pkg::MIN_FRAME) v = crx_pkg::VERDICT_SHORT;
    else if ({1'b0, rx_count} != crx_pkg::FRAME_OVERHEAD + rx_len)
      v = crx_pkg::VERDICT_LEN_MISMATCH;
    else if (rx_xor != 8'h00) v = crx_pkg::VERDICT_BAD_CSUM;
    else if (rx_type != ctrl_type_q) v = crx_pkg::VERDICT_WRONG_TYPE;
    else v = crx_pkg::VERDICT_OK;

    if (v == crx_pkg::VERDICT_OK) begin
      cmd = rx_first;
      case (cmd)
        crx_pkg::CMD_FRONT_ON:  lamp_front = 1'b1;
        crx_pkg::CMD_FRONT_OFF: lamp_front = 1'b0;
        crx_pkg::CMD_REAR_ON:   lamp_rear = 1'b1;
        crx_pkg::CMD_REAR_OFF:  lamp_rear = 1'b0;
        crx_pkg::CMD_BODY_ON:   lamp_body = 1'b1;
        crx_pkg::CMD_BODY_OFF:  lamp_body = 1'b0;
        default: ;
      endcase
    end

    res.verdict      = v;
    res.command_code = cmd;
    res.front_lamp   = lamp_front;
    res.rear_lamp    = lamp_rear;
    res.body_lamp    = lamp_body;
    // clear for the next write
    rx_count = '0;
    rx_xor   = '0;
    return 1'b1;
  endfunction

  // Assemble type, timestamp, length, payload and checksum, then cut or pad to n_bytes
  function automatic void build_frame(input logic [7:0] ftype, input logic [7:0] plen,
                                      input logic [7:0] cmd, input logic bad_sum,
                                      input int n_bytes);
    logic [7:0] b;
    logic [7:0] sum;
    int         i;
    frame_bytes.delete();
    sum = 8'h00;
    for (i = 0; i < 6 + int'(plen); i++) begin
      if (i == crx_pkg::POS_TYPE) b = ftype;
      else if (i == crx_pkg::POS_LENGTH) b = plen;
      else if (i == crx_pkg::POS_PAYLOAD) b = cmd;
      else b = 8'($urandom);
      sum ^= b;
      frame_bytes.push_back(b);
    end
    // spoil the checksum with a nonzero flip
    if (bad_sum) sum ^= 8'($urandom_range(1, 255));
    frame_bytes.push_back(sum);
    while (n_bytes > 0 && frame_bytes.size() > n_bytes)
      frame_bytes.delete(frame_bytes.size() - 1);
    while (frame_bytes.size() < n_bytes) frame_bytes.push_back(8'($urandom));
  endfunction

  // Drive one byte beat after an optional gap; hold it until the receiver takes it
  task automatic send_beat(input logic [7:0] data, input logic last,
                           input logic typed, input crx_pkg::frame_result_t typed_res);
    int                     gap;
    crx_pkg::frame_result_t res;
    gap = 0;
    if (in_calm > 0) begin
      in_calm--;
    end else begin
      // occasionally start a stretch of back-to-back beats
      if ($urandom_range(99) < 2) in_calm = $urandom_range(30, 120);
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= data;
    in_end_of_write <= last;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    if (deframe_byte(data, last, res)) pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic send_write(input logic typed, input crx_pkg::frame_result_t typed_res);
    int i;
    for (i = 0; i < frame_bytes.size(); i++)
      send_beat(frame_bytes[i], i == frame_bytes.size() - 1, typed, typed_res);
  endtask

  // Drop valid, drain every awaited result, then let the pipeline settle
  task automatic wait_idle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_control_type(input logic [7:0] code);
    cfg_valid             <= 1'b1;
    cfg_control_type_code <= code;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    ctrl_type_q = code;
    cfg_writes++;
  endtask

  // Mix of well-formed frames with random content, spoiled frames and noise
  task automatic random_write();
    int         pick;
    logic [7:0] ftype;
    logic [7:0] plen;
    logic [7:0] cmd;
    pick  = $urandom_range(99);
    ftype = ($urandom_range(9) < 8) ? ctrl_type_q : 8'($urandom);
    plen  = ($urandom_range(9) < 8) ? 8'($urandom_range(6)) : 8'($urandom_range(7, 24));
    cmd   = ($urandom_range(3) != 0)
          ? 8'($urandom_range(crx_pkg::CMD_FRONT_ON, crx_pkg::CMD_BODY_OFF))
          : 8'($urandom);
    if (pick < 70) build_frame(ftype, plen, cmd, 1'b0, 0);
    else if (pick < 80) build_frame(ftype, plen, cmd, 1'b1, 0);
    else if (pick < 90) build_frame(ftype, plen, cmd, 1'b0, $urandom_range(7, 32));
    else build_frame(8'($urandom), 8'($urandom), 8'($urandom), 1'b0,
                     $urandom_range(1, 12));
    send_write(1'b0, '0);
  endtask

  // Result side backpressure: random stalls, with calm stretches in between
  always @(posedge clk) begin
    if (out_calm > 0) begin
      out_calm--;
      out_stall <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold--;
      out_stall <= 1'b1;
    end else begin
      if ($urandom_range(99) < 2) out_calm = $urandom_range(40, 150);
      if ($urandom_range(3) == 0) out_hold = pick_gap();
      out_stall <= (out_hold > 0);
      if (out_hold > 0) out_hold--;
    end
  end

  // Check each taken result beat against the oldest awaited one, field by field
  always @(posedge clk) begin : result_check
    crx_pkg::frame_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      verdict_seen[out_verdict]++;
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result beat with none awaited: verdict %0d cmd %02h",
                                out_verdict, out_command_code));
      end else begin
        want = pending_results.pop_front();
        if (out_verdict !== want.verdict)
          note_mismatch($sformatf("verdict exp %0d got %0d", want.verdict, out_verdict));
        if (out_command_code !== want.command_code)
          note_mismatch($sformatf("command exp %02h got %02h",
                                  want.command_code, out_command_code));
        if (out_front_lamp !== want.front_lamp)
          note_mismatch($sformatf("front light exp %0b got %0b",
                                  want.front_lamp, out_front_lamp));
        if (out_rear_lamp !== want.rear_lamp)
          note_mismatch($sformatf("rear light exp %0b got %0b",
                                  want.rear_lamp, out_rear_lamp));
        if (out_body_lamp !== want.body_lamp)
          note_mismatch($sformatf("body light exp %0b got %0b",
                                  want.body_lamp, out_body_lamp));
      end
    end
  end

  initial begin : stimulus
    crx_pkg::frame_result_t fixed;
    frame_row_t             row;
    logic [7:0]             phase_codes [4];
    int                     p;
    int                     r;
    int                     start;
    foreach (verdict_seen[k]) verdict_seen[k] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames from the table
    for (r = 0; r < N_ROWS; r++) begin
      row = directed_rows[r];
      if (row.set_cfg) begin
        wait_idle();
        write_control_type(row.cfg_code);
      end
      fixed.verdict      = row.want_verdict;
      fixed.command_code = row.want_cmd;
      fixed.front_lamp   = row.want_lights[2];
      fixed.rear_lamp    = row.want_lights[1];
      fixed.body_lamp    = row.want_lights[0];
      build_frame(row.ftype, row.plen, row.cmd, row.bad_sum, int'(row.n_bytes));
      send_write(row.typed, fixed);
    end

    // Random phases; each starts from a drained receiver with a new control type
    phase_codes = '{8'hFF, 8'h00, 8'($urandom), 8'($urandom)};
    for (p = 0; p < 4; p++) begin
      wait_idle();
      write_control_type(phase_codes[p]);
      start = beats_sent;
      while (beats_sent - start < 85) random_write();
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      note_mismatch($sformatf("%0d awaited results never came", pending_results.size()));
      mismatches += pending_results.size() - 1;
    end

    $display("Run: %0d byte beats, %0d results, %0d control type writes",
             beats_sent, results_seen, cfg_writes);
    $display("Verdicts: ok %0d, short %0d, length %0d, checksum %0d, type %0d",
             verdict_seen[0], verdict_seen[1], verdict_seen[2], verdict_seen[3],
             verdict_seen[4]);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
